>>> rtl/button_press_blink_controller_assert.svh
// Assertion helpers for the checker file.
`ifndef BUTTON_PRESS_BLINK_CONTROLLER_ASSERT_SVH
`define BUTTON_PRESS_BLINK_CONTROLLER_ASSERT_SVH

// Same-cycle property, disabled while reset is asserted.
`define BPBC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Antecedent in this cycle, consequent in the next one.
`define BPBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bpbc_pkg.sv
package bpbc_pkg;

  localparam int CNT_W = 20;  // counter width
  localparam int REG_W = 20;  // config register width
  localparam int EXT_W = (CNT_W > REG_W) ? CNT_W : REG_W;

  localparam logic [REG_W-1:0] DEBOUNCE_RST = REG_W'(30000);
  localparam logic [REG_W-1:0] LONG_RST     = REG_W'(500000);
  localparam logic [REG_W-1:0] SLOW_RST     = REG_W'(1000000);
  localparam logic [REG_W-1:0] FAST_RST     = REG_W'(250000);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_LONG     = 2'd1,
    CFG_SLOW     = 2'd2,
    CFG_FAST     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_SLOW = 2'd1,
    MODE_FAST = 2'd2
  } mode_e;

  // Debounced press report for one tick.
  typedef struct packed {
    logic event_v;
    logic is_long;
  } press_t;

  // Zero acts as one; values above the counter range clamp to its top.
  function automatic logic [CNT_W-1:0] eff_ticks(input logic [REG_W-1:0] r);
    logic [EXT_W-1:0] v;
    v = EXT_W'(r);
    if (v == '0) begin
      v = EXT_W'(1);
    end
    if (v > EXT_W'(CNT_MAX)) begin
      v = EXT_W'(CNT_MAX);
    end
    return v[CNT_W-1:0];
  endfunction

endpackage

>>> rtl/bpbc_debounce.sv
module bpbc_debounce (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic                   level_i,
  input  logic [bpbc_pkg::CNT_W-1:0] debounce_i,
  input  logic [bpbc_pkg::CNT_W-1:0] long_i,
  output bpbc_pkg::press_t       press_o
);
  import bpbc_pkg::*;

  logic             last_level_q, last_level_d;
  logic [CNT_W-1:0] db_cnt_q, db_cnt_d;
  logic             held_q, held_d;
  logic [CNT_W-1:0] press_cnt_q, press_cnt_d;
  press_t           press;

  always_comb begin
    press       = '0;
    held_d      = held_q;
    db_cnt_d    = db_cnt_q;
    press_cnt_d = press_cnt_q;
    if (held_q && (press_cnt_q < long_i)) begin
      press_cnt_d = press_cnt_q + CNT_W'(1);
    end
    if (db_cnt_q != '0) begin
      db_cnt_d = db_cnt_q - CNT_W'(1);
      if (db_cnt_d == '0) begin
        // sample at expiry
        if (!level_i && !held_q) begin
          held_d      = 1'b1;
          press_cnt_d = '0;
        end else if (level_i && held_q) begin
          press.event_v = 1'b1;
          press.is_long = (press_cnt_d >= long_i);
          held_d        = 1'b0;
        end
      end
    end else if (level_i != last_level_q) begin
      db_cnt_d = debounce_i;
    end
    last_level_d = level_i;
  end

  assign press_o = press;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q <= 1'b1;
      db_cnt_q     <= '0;
      held_q       <= 1'b0;
      press_cnt_q  <= '0;
    end else if (accept_i) begin
      last_level_q <= last_level_d;
      db_cnt_q     <= db_cnt_d;
      held_q       <= held_d;
      press_cnt_q  <= press_cnt_d;
    end
  end

endmodule

>>> rtl/bpbc_blink.sv
module bpbc_blink (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  bpbc_pkg::press_t       press_i,
  input  logic [bpbc_pkg::CNT_W-1:0] slow_i,
  input  logic [bpbc_pkg::CNT_W-1:0] fast_i,
  output logic                   led_o,
  output bpbc_pkg::mode_e        mode_o
);
  import bpbc_pkg::*;

  logic             app_on_q, app_on_d;
  mode_e            mode_q, mode_d;
  logic [CNT_W-1:0] blink_cnt_q, blink_cnt_d;
  logic             toggle_q, toggle_d;
  logic             pin_q, pin_d;
  logic [CNT_W-1:0] per;
  logic [CNT_W-1:0] nxt;
  logic             blinking;

  always_comb begin
    app_on_d    = app_on_q;
    mode_d      = mode_q;
    blink_cnt_d = blink_cnt_q;
    toggle_d    = toggle_q;
    pin_d       = pin_q;
    per         = slow_i;
    blinking    = 1'b0;
    nxt         = blink_cnt_q + CNT_W'(1);
    unique case (mode_q)
      MODE_SLOW: begin
        per      = slow_i;
        blinking = 1'b1;
      end
      MODE_FAST: begin
        per      = fast_i;
        blinking = 1'b1;
      end
      default: begin
        blinking = 1'b0;
      end
    endcase
    if (blinking) begin
      // wrap of the counter also counts as period end
      if ((nxt >= per) || (nxt == '0)) begin
        blink_cnt_d = '0;
        toggle_d    = ~toggle_q;
        pin_d       = ~toggle_q;
      end else begin
        blink_cnt_d = nxt;
      end
    end
    if (press_i.event_v) begin
      if (press_i.is_long) begin
        mode_d = MODE_FAST;
      end else begin
        app_on_d = ~app_on_q;
        mode_d   = app_on_d ? MODE_SLOW : MODE_OFF;
      end
      blink_cnt_d = '0;
      if (mode_d == MODE_OFF) begin
        pin_d = 1'b0;
      end
    end
  end

  assign led_o  = pin_d;
  assign mode_o = mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      app_on_q    <= 1'b0;
      mode_q      <= MODE_OFF;
      blink_cnt_q <= '0;
      toggle_q    <= 1'b0;
      pin_q       <= 1'b0;
    end else if (accept_i) begin
      app_on_q    <= app_on_d;
      mode_q      <= mode_d;
      blink_cnt_q <= blink_cnt_d;
      toggle_q    <= toggle_d;
      pin_q       <= pin_d;
    end
  end

endmodule

>>> rtl/button_press_blink_controller.sv
// Button debounce / long-press detector driving a blinking LED.
//
// Input stream: one transfer per 1 us tick, s_axis_tdata[0] is the raw
// button level (0 pressed, 1 released). Output stream: exactly one
// result transfer per input transfer, carrying the LED level, the
// press report and the current blink mode after that tick.
//
// Latency: a result is valid on the cycle after its input transfer.
// Throughput: one tick per cycle; all counter updates and compares of
// a tick fit between the state registers and the result register.
// Stall: the result register holds while m_axis_tready is low; a new
// tick is taken in the same cycle the waiting result is taken, so
// s_axis_tready = !m_axis_tvalid || m_axis_tready.
//
// Reset: button seen as released, no debounce running, mode off, LED
// low, config registers at 30000 / 500000 / 1000000 / 250000 ticks.
// Config writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at the
// next clock edge; write only while the stream is idle.
module button_press_blink_controller (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // slave side
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [0] button_level, [7:1] zero
  // master side
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,   // [0] led_level, [1] press_event,
                                                     // [2] press_long, [4:3] blink_mode,
                                                     // [7:5] zero
  // config write port
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [bpbc_pkg::REG_W-1:0] cfg_wdata_i
);
  import bpbc_pkg::*;

  logic [REG_W-1:0] debounce_q, long_q, slow_q, fast_q;
  logic             accept;
  press_t           press;
  logic             led_d;
  mode_e            mode_d;
  logic             out_valid_q;
  logic [7:0]       out_data_q, out_data_d;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RST;
      long_q     <= LONG_RST;
      slow_q     <= SLOW_RST;
      fast_q     <= FAST_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE: debounce_q <= cfg_wdata_i;
        CFG_LONG:     long_q     <= cfg_wdata_i;
        CFG_SLOW:     slow_q     <= cfg_wdata_i;
        CFG_FAST:     fast_q     <= cfg_wdata_i;
        default:      debounce_q <= debounce_q;
      endcase
    end
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  bpbc_debounce u_debounce (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .level_i    (s_axis_tdata[0]),
    .debounce_i (eff_ticks(debounce_q)),
    .long_i     (eff_ticks(long_q)),
    .press_o    (press)
  );

  bpbc_blink u_blink (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .press_i  (press),
    .slow_i   (eff_ticks(slow_q)),
    .fast_i   (eff_ticks(fast_q)),
    .led_o    (led_d),
    .mode_o   (mode_d)
  );

  assign out_data_d = {3'b000, mode_d, press.is_long, press.event_v, led_d};

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> rtl/bpbc_checker.sv
`include "button_press_blink_controller_assert.svh"

module bpbc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);
  import bpbc_pkg::*;

  // an empty output register never blocks the input
  `BPBC_ASSERT(a_ready_when_empty, clk_i, rst_ni,
    !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")

  `BPBC_ASSERT_NEXT(a_hold_on_stall, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // long flag only with a press report
  `BPBC_ASSERT(a_long_needs_event, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1], "press_long without press_event")

  `BPBC_ASSERT(a_off_led_low, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tdata[4:3] == MODE_OFF) |-> !m_axis_tdata[0],
    "LED high in off mode")

  `BPBC_ASSERT(a_mode_legal, clk_i, rst_ni,
    m_axis_tvalid |-> (m_axis_tdata[4:3] != 2'd3) && (m_axis_tdata[7:5] == 3'd0),
    "bad blink mode or padding")

endmodule

bind button_press_blink_controller bpbc_checker u_bpbc_checker (.*);

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import bpbc_pkg::*;

  localparam int CW = CNT_W;
  localparam int RW = REG_W;

  // One tick's worth of LED and press report, packed like m_axis_tdata[4:0].
  typedef struct packed {
    mode_e mode;
    logic  press_long;
    logic  press_event;
    logic  led_level;
  } tick_result_t;

  logic          clk_i         = 1'b0;
  logic          rst_ni        = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  wire           s_axis_tready;
  logic [7:0]    s_axis_tdata  = 8'h01;
  wire           m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  wire  [7:0]    m_axis_tdata;
  logic          cfg_we_i      = 1'b0;
  cfg_idx_e      cfg_idx_i     = CFG_DEBOUNCE;
  logic [RW-1:0] cfg_wdata_i   = '0;

  button_press_blink_controller i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow of the controller: thresholds and state after reset.
  logic [RW-1:0] sh_debounce = RW'(30000);
  logic [RW-1:0] sh_long     = RW'(500000);
  logic [RW-1:0] sh_slow     = RW'(1000000);
  logic [RW-1:0] sh_fast     = RW'(250000);

  logic          lvl_q   = 1'b1;
  logic [CW-1:0] deb_q   = '0;
  logic          held_q  = 1'b0;
  logic [CW-1:0] dur_q   = '0;
  logic          on_q    = 1'b0;
  mode_e         mode_q  = MODE_OFF;
  logic [CW-1:0] blink_q = '0;
  logic          tog_q   = 1'b0;
  logic          pin_q   = 1'b0;

  tick_result_t expected_ticks[$];
  int           errors       = 0;
  bit           tx_idle_en   = 1'b1;
  bit           rx_idle_en   = 1'b1;
  int           stall_cycles = 0;

  // Zero means one tick; anything past the counter range pins to its top.
  function automatic logic [CW-1:0] limit_ticks(input logic [RW-1:0] r);
    longint unsigned v;
    v = 64'(r);
    if (v == 0) v = 1;
    if (v > (64'd1 << CW) - 1) v = (64'd1 << CW) - 1;
    return CW'(v);
  endfunction

  // Advance the shadow by one tick and return what the block should report.
  task automatic tick_predict(input logic lvl, output tick_result_t res);
    logic [CW-1:0] per;
    logic [CW-1:0] nxt;
    logic [CW-1:0] lp;
    logic          ev;
    logic          lng;
    ev  = 1'b0;
    lng = 1'b0;
    lp  = limit_ticks(sh_long);
    // blink period, restarts on reaching the period or on counter wrap
    if (mode_q == MODE_SLOW || mode_q == MODE_FAST) begin
      per = limit_ticks(mode_q == MODE_SLOW ? sh_slow : sh_fast);
      nxt = blink_q + 1'b1;
      if (nxt >= per || nxt == '0) begin
        blink_q = '0;
        tog_q   = ~tog_q;
        pin_q   = tog_q;
      end else begin
        blink_q = nxt;
      end
    end
    if (held_q && dur_q < lp) dur_q = dur_q + 1'b1;
    // one-shot debounce; edges are ignored while it runs
    if (deb_q != '0) begin
      deb_q = deb_q - 1'b1;
      if (deb_q == '0) begin
        if (!lvl && !held_q) begin
          held_q = 1'b1;
          dur_q  = '0;
        end else if (lvl && held_q) begin
          ev     = 1'b1;
          lng    = (dur_q >= lp);
          held_q = 1'b0;
        end
      end
    end else if (lvl != lvl_q) begin
      deb_q = limit_ticks(sh_debounce);
    end
    if (ev) begin
      if (lng) begin
        mode_q = MODE_FAST;
      end else begin
        on_q   = ~on_q;
        mode_q = on_q ? MODE_SLOW : MODE_OFF;
      end
      blink_q = '0;
      if (mode_q == MODE_OFF) pin_q = 1'b0;
    end
    lvl_q = lvl;
    res.led_level   = pin_q;
    res.press_event = ev;
    res.press_long  = lng;
    res.mode        = mode_q;
  endtask

  function automatic void check_field(input string what, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
      errors++;
    end
  endfunction

  // Transfer monitor: predict on every input transfer, check every output one.
  always @(posedge clk_i) begin
    tick_result_t exp_r;
    tick_result_t got_r;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_r.led_level   = m_axis_tdata[0];
        got_r.press_event = m_axis_tdata[1];
        got_r.press_long  = m_axis_tdata[2];
        got_r.mode        = mode_e'(m_axis_tdata[4:3]);
        if (expected_ticks.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %b", $time, m_axis_tdata);
          errors++;
        end else begin
          exp_r = expected_ticks.pop_front();
          check_field("led_level", exp_r.led_level, got_r.led_level);
          check_field("press_event", exp_r.press_event, got_r.press_event);
          check_field("press_long", exp_r.press_long, got_r.press_long);
          check_field("blink_mode", exp_r.mode, got_r.mode);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tick_predict(s_axis_tdata[0], exp_r);
        expected_ticks.push_back(exp_r);
      end
    end
  end

  // Result sink: random hold-off per result, plus a long stall on request.
  initial begin : result_sink
    int wait_n;
    forever begin
      wait_n = rx_idle_en ? $urandom_range(0, 13) : 0;
      if (stall_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall_cycles) @(posedge clk_i);
        stall_cycles = 0;
      end
      if (wait_n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Offer one tick after a random gap and hold it until the transfer.
  task automatic send_tick(input logic lvl);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, lvl};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_run(input logic lvl, input int n);
    repeat (n) send_tick(lvl);
  endtask

  // Directed ticks, one character per tick: '0' pressed, '1' released.
  task automatic send_pattern(input string pat);
    for (int i = 0; i < pat.len(); i++) send_tick(pat[i] == "0" ? 1'b0 : 1'b1);
  endtask

  // Stop offering and wait until every result is back, plus a little slack.
  task automatic drain_ticks();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_ticks.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [RW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_DEBOUNCE: sh_debounce = val;
      CFG_LONG:     sh_long     = val;
      CFG_SLOW:     sh_slow     = val;
      CFG_FAST:     sh_fast     = val;
      default: ;
    endcase
  endtask

  // Only called with the stream drained.
  task automatic set_config(input logic [RW-1:0] deb, input logic [RW-1:0] lng,
                            input logic [RW-1:0] slw, input logic [RW-1:0] fst);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_LONG, lng);
    write_reg(CFG_SLOW, slw);
    write_reg(CFG_FAST, fst);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reset thresholds: stay released, an edge here would keep the
  // 30000-tick debounce busy for the rest of the run.
  task automatic test_reset_config();
    send_pattern("11");
    drain_ticks();
  endtask

  // Zero registers act as one: long press into fast blink, then a
  // glitch whose sample matches the idle state and whose return edge
  // lands on the expiry tick.
  task automatic test_min_settings();
    set_config('0, RW'(1), '0, RW'(1));
    send_pattern("0001101");
    drain_ticks();
  endtask

  // Short press, then an edge while counting and one on the expiry tick.
  task automatic test_press_types();
    set_config(RW'(2), RW'(6), RW'(3), RW'(2));
    send_pattern("0000111010111");
    drain_ticks();
  endtask

  // All thresholds at the top of the range, level held so no debounce starts.
  task automatic test_max_settings();
    set_config('1, '1, '1, '1);
    send_pattern("1111");
    drain_ticks();
  endtask

  // Mostly well-formed presses of random length, some glitches and noise.
  task automatic test_random_presses(input int phases, input int per_phase);
    int            sent;
    int            kind;
    int            n;
    int            deb_eff;
    int            lp_eff;
    logic [RW-1:0] deb;
    logic [RW-1:0] lng;
    logic [RW-1:0] slw;
    logic [RW-1:0] fst;
    for (int p = 0; p < phases; p++) begin
      deb = RW'($urandom_range(0, 5));
      lng = RW'($urandom_range(0, 25));
      slw = RW'($urandom_range(0, 24));
      fst = RW'($urandom_range(0, 12));
      if (p == 0) begin
        deb = RW'(1);
        lng = RW'(1);
        slw = '0;
        fst = RW'(1);
      end
      set_config(deb, lng, slw, fst);
      // one phase in three without sender gaps, one in three without receiver gaps
      tx_idle_en = (p % 3 != 1);
      rx_idle_en = (p % 3 != 2);
      deb_eff = (deb == 0) ? 1 : int'(deb);
      lp_eff  = (lng == 0) ? 1 : int'(lng);
      sent = 0;
      while (sent < per_phase) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          n = deb_eff + $urandom_range(1, 2 * lp_eff + 2);
          send_run(1'b0, n);
          sent += n;
          n = deb_eff + $urandom_range(1, 6);
          send_run(1'b1, n);
          sent += n;
        end else if (kind < 9) begin
          n = $urandom_range(1, deb_eff + 1);
          send_run(1'b0, n);
          send_tick(1'b1);
          sent += n + 1;
        end else begin
          n = $urandom_range(1, 6);
          repeat (n) send_tick(1'($urandom_range(0, 1)));
          sent += n;
        end
      end
      drain_ticks();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Receiver stalls for a long stretch while ticks keep coming back to back.
  task automatic test_output_stall();
    tx_idle_en   = 1'b0;
    rx_idle_en   = 1'b0;
    stall_cycles = 400;
    send_run(1'b0, 20);
    send_run(1'b1, 20);
    drain_ticks();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config();
    test_min_settings();
    test_press_types();
    test_max_settings();
    test_random_presses(6, 140);
    test_output_stall();
    if (expected_ticks.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0", $time,
               expected_ticks.size());
      errors++;
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3600000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
